### sv/sdht_pkg.sv
// ---------------------------------------------------------------------------
// sdht_pkg: shared types and codes for the surface damage history tracker
// Request kinds, result status codes, box and bounding-box types, FSM states.
// ---------------------------------------------------------------------------
package sdht_pkg;

    localparam int SERIAL_W = 32;
    localparam int SIZE_W   = 15;
    localparam int BOX_W    = 64;
    localparam int ENTRY_W  = SERIAL_W + BOX_W;
    localparam int COORD_W  = 18;

    localparam logic [1:0] KIND_COMMIT = 2'd0;
    localparam logic [1:0] KIND_DAMAGE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_ACK   = 2'd0;
    localparam logic [1:0] STATUS_COPY  = 2'd1;
    localparam logic [1:0] STATUS_REUSE = 2'd2;

    localparam logic [SERIAL_W-1:0] SERIAL_MAX = '1;

    // damage box, x in the low bits
    typedef struct packed {
        logic signed [15:0] h;
        logic signed [15:0] w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_box;

    // running bounding box, right/bottom edges exclusive
    typedef struct packed {
        logic                      any;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } t_bbox;

    typedef struct packed {
        logic clear;
        logic add;
    } t_union_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_QCHECK,
        ST_WALK,
        ST_CUR,
        ST_CLAMP,
        ST_RESP
    } t_state;

endpackage

### sv/sdht_hist_ram.sv
// ---------------------------------------------------------------------------
// sdht_hist_ram: history entry storage
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sdht_hist_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 96
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sdht_union.sv
// ---------------------------------------------------------------------------
// sdht_union: shared bounding-box union unit
// Folds one box per cycle into an accumulator; empty boxes are ignored.
// ---------------------------------------------------------------------------
module sdht_union (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdht_pkg::t_union_ctl i_ctl,
    input  sdht_pkg::t_box       i_box,
    output sdht_pkg::t_bbox      o_acc
);

    sdht_pkg::t_bbox r_acc;
    sdht_pkg::t_bbox n_acc;

    logic                               live;
    logic signed [sdht_pkg::COORD_W-1:0] bx0;
    logic signed [sdht_pkg::COORD_W-1:0] by0;
    logic signed [sdht_pkg::COORD_W-1:0] bx1;
    logic signed [sdht_pkg::COORD_W-1:0] by1;

    assign live = (i_box.w > 16'sd0) && (i_box.h > 16'sd0);
    assign bx0  = {{2{i_box.x[15]}}, i_box.x};
    assign by0  = {{2{i_box.y[15]}}, i_box.y};
    assign bx1  = bx0 + {{2{i_box.w[15]}}, i_box.w};
    assign by1  = by0 + {{2{i_box.h[15]}}, i_box.h};

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.add && live) begin
            if (!r_acc.any) begin
                n_acc.any = 1'b1;
                n_acc.x0  = bx0;
                n_acc.y0  = by0;
                n_acc.x1  = bx1;
                n_acc.y1  = by1;
            end else begin
                if (bx0 < r_acc.x0) n_acc.x0 = bx0;
                if (by0 < r_acc.y0) n_acc.y0 = by0;
                if (bx1 > r_acc.x1) n_acc.x1 = bx1;
                if (by1 > r_acc.y1) n_acc.y1 = by1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### sv/surface_damage_history_tracker_top.sv
// ---------------------------------------------------------------------------
// surface_damage_history_tracker_top: damage history of one surface
// Keeps epoch, serial, geometry and a ring of serial-stamped damage boxes;
// answers texture upload queries with the region that must be copied.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser kind, tdata item fields
//  m_axis    out        tvalid/tready          tuser status, tdata region/stamps
//  cfg       in         i_cfg_we (no wait)     i_cfg_wdata surface_id
//
//  Commit, damage and ignored requests pass through decode to the response
//  state; a query may add the history check, the walk over the kept history
//  entries, the current box and the clamp, and its time is set by the walk:
//  one RAM read and one pass of the shared union unit per entry. Reset is
//  synchronous, active low; the history RAM is not cleared, only entries below
//  the fill count are read. A result waits in the output register; the
//  sequencer holds before loading it while the previous result is still not taken.
// ---------------------------------------------------------------------------
module surface_damage_history_tracker_top #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [14:0] width, [29:15] height, [30] remap, [46:31] box_x,
    // [62:47] box_y, [78:63] box_w, [94:79] box_h, [95] texture_fresh,
    // [127:96] owner_id, [159:128] tex_epoch, [191:160] tex_serial
    input  logic [191:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [14:0] copy_x, [29:15] copy_y, [44:30] copy_w, [59:45] copy_h,
    // [91:60] new_epoch, [123:92] new_serial, [127:124] zero
    output logic [127:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;
    localparam int CW    = sdht_pkg::COORD_W;
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(HISTORY_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // state
    sdht_pkg::t_state r_state;
    sdht_pkg::t_state n_state;

    logic [31:0]      r_surface_id;
    logic [31:0]      r_epoch;
    logic [31:0]      r_serial;
    logic [14:0]      r_hist_w;
    logic [14:0]      r_hist_h;
    logic             r_geom_valid;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_remaining;
    logic             r_first;

    // captured request
    logic [1:0]       r_kind;
    logic [14:0]      r_w;
    logic [14:0]      r_h;
    logic             r_remap;
    sdht_pkg::t_box   r_box;
    logic             r_fresh;
    logic [31:0]      r_owner;
    logic [31:0]      r_oepoch;
    logic [31:0]      r_cserial;

    // pending result
    logic [1:0]       r_res_status;
    logic [14:0]      r_res_x;
    logic [14:0]      r_res_y;
    logic [14:0]      r_res_w;
    logic [14:0]      r_res_h;
    logic             r_res_stamp;

    // output register
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [127:0]     r_out_data;

    logic s_accept;
    logic res_load;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == sdht_pkg::ST_IDLE);
    assign res_load      = (r_state == sdht_pkg::ST_RESP) && (!r_out_valid || m_axis_tready);

    // derived decode terms
    logic             box_live;
    logic             serial_ones;
    logic [CNT_W-1:0] eff_count;
    logic             full;
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_ptr;
    logic [31:0]      dmg_serial;
    logic [31:0]      epoch_inc;
    logic [31:0]      epoch_next;
    logic             c_valid;
    logic             c_reset;
    logic             q_empty;
    logic             q_reset;
    logic             q_base;
    logic [31:0]      cs_plus1;

    assign box_live    = (r_box.w > 16'sd0) && (r_box.h > 16'sd0);
    assign serial_ones = (r_serial == sdht_pkg::SERIAL_MAX);
    assign eff_count   = serial_ones ? '0 : r_count;
    assign full        = (eff_count == DEPTH_C);
    // when full this wraps back onto the head, i.e. the oldest entry
    assign wr_sum      = SUM_W'(r_head) + SUM_W'(eff_count);
    assign wr_ptr      = (wr_sum >= DEPTH_S) ? PTR_W'(wr_sum - DEPTH_S) : PTR_W'(wr_sum);
    assign dmg_serial  = serial_ones ? 32'd1 : r_serial + 32'd1;
    assign epoch_inc   = r_epoch + 32'd1;
    assign epoch_next  = (epoch_inc == 32'd0) ? 32'd1 : epoch_inc;
    assign c_valid     = (r_w != '0) && (r_h != '0);
    assign c_reset     = r_remap || (r_geom_valid != c_valid) ||
                         (c_valid && ((r_hist_w != r_w) || (r_hist_h != r_h)));
    assign q_empty     = (r_w == '0) || (r_h == '0);
    assign q_reset     = box_live && serial_ones;
    assign q_base      = !r_fresh && r_geom_valid && (r_owner == r_surface_id) &&
                         (r_oepoch == r_epoch) && (r_cserial <= r_serial);
    assign cs_plus1    = r_cserial + 32'd1;

    // history RAM
    logic                         ram_we;
    logic [PTR_W-1:0]             ram_raddr;
    logic [sdht_pkg::ENTRY_W-1:0] ram_rdata;
    logic [31:0]                  e_serial;
    sdht_pkg::t_box               e_box;
    logic                         stale_first;
    logic                         e_newer;

    assign e_serial    = ram_rdata[sdht_pkg::ENTRY_W-1 -: 32];
    assign e_box       = sdht_pkg::t_box'(ram_rdata[sdht_pkg::BOX_W-1:0]);
    assign stale_first = r_first && (e_serial > cs_plus1);
    assign e_newer     = e_serial > r_cserial;

    sdht_hist_ram #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (sdht_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_ptr),
        .i_wdata ({dmg_serial, r_box}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // union unit
    sdht_pkg::t_union_ctl uni_ctl;
    sdht_pkg::t_box       uni_box;
    sdht_pkg::t_bbox      acc;

    assign uni_box = (r_state == sdht_pkg::ST_WALK) ? e_box : r_box;

    sdht_union u_union (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (uni_ctl),
        .i_box   (uni_box),
        .o_acc   (acc)
    );

    // clamp of the union to the buffer
    logic signed [CW-1:0] buf_w;
    logic signed [CW-1:0] buf_h;
    logic signed [CW-1:0] cl_x;
    logic signed [CW-1:0] cl_y;
    logic signed [CW-1:0] cl_r;
    logic signed [CW-1:0] cl_b;
    logic signed [CW-1:0] cl_w;
    logic signed [CW-1:0] cl_h;
    logic                 cl_copy;

    assign buf_w   = {3'b000, r_w};
    assign buf_h   = {3'b000, r_h};
    assign cl_x    = (acc.x0 < 0) ? '0 : acc.x0;
    assign cl_y    = (acc.y0 < 0) ? '0 : acc.y0;
    assign cl_r    = (acc.x1 < buf_w) ? acc.x1 : buf_w;
    assign cl_b    = (acc.y1 < buf_h) ? acc.y1 : buf_h;
    assign cl_w    = cl_r - cl_x;
    assign cl_h    = cl_b - cl_y;
    assign cl_copy = acc.any && (cl_x < buf_w) && (cl_y < buf_h) && (cl_w > 0) && (cl_h > 0);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdht_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_raddr = r_rd_ptr;
        uni_ctl   = '0;
        case (r_state)
            sdht_pkg::ST_IDLE: begin
                if (s_accept) n_state = sdht_pkg::ST_DECODE;
            end
            sdht_pkg::ST_DECODE: begin
                n_state = sdht_pkg::ST_RESP;
                if (r_kind == sdht_pkg::KIND_DAMAGE) begin
                    ram_we = box_live;
                end else if (r_kind == sdht_pkg::KIND_QUERY && !q_empty) begin
                    n_state = sdht_pkg::ST_QCHECK;
                end
            end
            sdht_pkg::ST_QCHECK: begin
                ram_raddr     = r_head;
                uni_ctl.clear = 1'b1;
                if (!q_base) begin
                    n_state = sdht_pkg::ST_RESP;
                end else if (r_cserial == r_serial) begin
                    n_state = sdht_pkg::ST_CUR;
                end else if (r_count == '0) begin
                    n_state = sdht_pkg::ST_RESP;
                end else begin
                    n_state = sdht_pkg::ST_WALK;
                end
            end
            sdht_pkg::ST_WALK: begin
                if (stale_first) begin
                    n_state = sdht_pkg::ST_RESP;
                end else begin
                    uni_ctl.add = e_newer;
                    if (r_remaining == CNT_W'(1)) n_state = sdht_pkg::ST_CUR;
                end
            end
            sdht_pkg::ST_CUR: begin
                uni_ctl.add = 1'b1;
                n_state     = sdht_pkg::ST_CLAMP;
            end
            sdht_pkg::ST_CLAMP: begin
                n_state = sdht_pkg::ST_RESP;
            end
            sdht_pkg::ST_RESP: begin
                if (res_load) n_state = sdht_pkg::ST_IDLE;
            end
            default: begin
                n_state = sdht_pkg::ST_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind    <= s_axis_tuser;
            r_w       <= s_axis_tdata[14:0];
            r_h       <= s_axis_tdata[29:15];
            r_remap   <= s_axis_tdata[30];
            r_box     <= sdht_pkg::t_box'(s_axis_tdata[94:31]);
            r_fresh   <= s_axis_tdata[95];
            r_owner   <= s_axis_tdata[127:96];
            r_oepoch  <= s_axis_tdata[159:128];
            r_cserial <= s_axis_tdata[191:160];
        end
    end

    // history state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_id <= '0;
            r_epoch      <= '0;
            r_serial     <= '0;
            r_hist_w     <= '0;
            r_hist_h     <= '0;
            r_geom_valid <= 1'b0;
            r_count      <= '0;
            r_head       <= '0;
        end else begin
            if (i_cfg_we) r_surface_id <= i_cfg_wdata;
            if (r_state == sdht_pkg::ST_DECODE) begin
                case (r_kind)
                    sdht_pkg::KIND_COMMIT: begin
                        if (c_reset) begin
                            r_epoch      <= epoch_next;
                            r_serial     <= '0;
                            r_hist_w     <= r_w;
                            r_hist_h     <= r_h;
                            r_geom_valid <= c_valid;
                            r_count      <= '0;
                        end
                    end
                    sdht_pkg::KIND_DAMAGE: begin
                        if (box_live) begin
                            if (serial_ones) r_epoch <= epoch_next;
                            r_serial <= dmg_serial;
                            if (full) begin
                                r_head <= ptr_inc(r_head);
                            end else begin
                                r_count <= eff_count + CNT_W'(1);
                            end
                        end
                    end
                    sdht_pkg::KIND_QUERY: begin
                        if (!q_empty && q_reset) begin
                            r_epoch      <= epoch_next;
                            r_serial     <= '0;
                            r_hist_w     <= r_w;
                            r_hist_h     <= r_h;
                            r_geom_valid <= 1'b1;
                            r_count      <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // walk pointers and pending result
    always_ff @(posedge i_clk) begin
        case (r_state)
            sdht_pkg::ST_DECODE: begin
                r_res_status <= sdht_pkg::STATUS_ACK;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_w      <= '0;
                r_res_h      <= '0;
                r_res_stamp  <= 1'b0;
            end
            sdht_pkg::ST_QCHECK: begin
                r_res_stamp <= 1'b1;
                r_rd_ptr    <= ptr_inc(r_head);
                r_remaining <= r_count;
                r_first     <= 1'b1;
                // stale history or nothing kept: full frame
                if (!q_base || (r_cserial != r_serial && r_count == '0)) begin
                    r_res_status <= sdht_pkg::STATUS_COPY;
                    r_res_w      <= r_w;
                    r_res_h      <= r_h;
                end
            end
            sdht_pkg::ST_WALK: begin
                r_rd_ptr    <= ptr_inc(r_rd_ptr);
                r_remaining <= r_remaining - CNT_W'(1);
                r_first     <= 1'b0;
                if (stale_first) begin
                    r_res_status <= sdht_pkg::STATUS_COPY;
                    r_res_w      <= r_w;
                    r_res_h      <= r_h;
                end
            end
            sdht_pkg::ST_CLAMP: begin
                if (cl_copy) begin
                    r_res_status <= sdht_pkg::STATUS_COPY;
                    r_res_x      <= cl_x[14:0];
                    r_res_y      <= cl_y[14:0];
                    r_res_w      <= cl_w[14:0];
                    r_res_h      <= cl_h[14:0];
                end else begin
                    r_res_status <= sdht_pkg::STATUS_REUSE;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    logic [31:0] out_epoch;
    logic [31:0] out_serial;

    assign out_epoch  = r_res_stamp ? r_epoch : '0;
    assign out_serial = r_res_stamp ? (r_serial + {31'b0, box_live}) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= {4'b0000, out_serial, out_epoch,
                             r_res_h, r_res_w, r_res_y, r_res_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("history fill count beyond depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_axis_tready)
        else $error("request taken while previous one in work");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdht_pkg::ST_RESP && r_out_valid && !m_axis_tready)
            |=> (r_state == sdht_pkg::ST_RESP))
        else $error("result loaded over a pending one");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdht_pkg::ST_WALK) |-> (r_remaining != '0))
        else $error("history walk with no entries left");

endmodule
